// File: rtl/lfbs_pkg.sv
`default_nettype none

package lfbs_pkg;

  localparam int unsigned DUTY_BITS_DEF = 8;
  localparam int unsigned DUTY_BITS_MAX = 16;
  localparam int unsigned FADE_W        = 10;
  localparam int unsigned HOLD_W        = 16;
  localparam int unsigned BRIGHT_W      = 9;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [FADE_W-1:0]   FADE_RST   = 10'd50;
  localparam logic [HOLD_W-1:0]   HOLD_RST   = 16'd300;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 9'd256;
  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 9'd256;

  localparam logic [1:0] SND_FULL  = 2'd1;
  localparam logic [1:0] SND_START = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE   = 2'd0,
    CFG_HOLD   = 2'd1,
    CFG_BRIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_FADE  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_UP    = 3'd1,
    PH_HOLD  = 3'd2,
    PH_DOWN  = 3'd3,
    PH_DARK  = 3'd4,
    PH_IDLE  = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RAMP = 2'd2,
    S_OUT  = 2'd3
  } seq_state_e;

  typedef enum logic [1:0] {
    R_IDLE = 2'd0,
    R_MUL  = 2'd1,
    R_DIV  = 2'd2
  } ramp_state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [15:0] wait_ms;
    logic [1:0]  sound_mode;
  } lfbs_in_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       lit;
    logic       tone_pulse;
  } lfbs_out_t;

  typedef struct packed {
    logic                start;
    logic [FADE_W-1:0]   num;
    logic [FADE_W-1:0]   den;
    logic [BRIGHT_W-1:0] scale;
  } lfbs_ramp_req_t;

endpackage

`default_nettype wire

// File: rtl/lfbs_ramp_unit.sv
`default_nettype none

module lfbs_ramp_unit #(
  parameter int unsigned DutyBits = lfbs_pkg::DUTY_BITS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  lfbs_pkg::lfbs_ramp_req_t     req_i,
  output logic                         done_o,
  output logic [DutyBits-1:0]          quot_o
);
  import lfbs_pkg::*;

  localparam int unsigned CntW  = $clog2(DutyBits);
  localparam int unsigned MnumW = DutyBits + FADE_W;
  localparam int unsigned ProdW = DutyBits + FADE_W + BRIGHT_W;

  ramp_state_e state_q, state_d;

  logic [FADE_W-1:0]   num_q, num_d;
  logic [FADE_W-1:0]   den_q, den_d;
  logic [BRIGHT_W-1:0] scale_q, scale_d;
  logic [FADE_W-1:0]   rem_q, rem_d;
  logic [DutyBits-1:0] sh_q, sh_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                done_q, done_d;

  logic [MnumW-1:0]  mnum;
  logic [ProdW-1:0]  prod;
  logic [FADE_W:0]   trial;
  logic [FADE_W:0]   diff;
  logic              qbit;

  // num * (2^n - 1) then one multiply by the brightness scale
  assign mnum  = {num_q, {DutyBits{1'b0}}} - MnumW'(num_q);
  assign prod  = ProdW'(mnum) * ProdW'(scale_q);
  assign trial = {rem_q, sh_q[DutyBits-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      R_IDLE: begin
        if (req_i.start) state_d = R_MUL;
      end
      R_MUL: state_d = R_DIV;
      R_DIV: begin
        if (cnt_q == '0) state_d = R_IDLE;
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_comb begin
    num_d   = num_q;
    den_d   = den_q;
    scale_d = scale_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          num_d   = req_i.num;
          den_d   = req_i.den;
          scale_d = req_i.scale;
        end
      end
      R_MUL: begin
        // dividend is prod >> 8; its bits above the quotient width stay below den
        rem_d = prod[DutyBits+17:DutyBits+8];
        sh_d  = prod[DutyBits+7:8];
        cnt_d = CntW'(DutyBits - 1);
      end
      R_DIV: begin
        rem_d = qbit ? diff[FADE_W-1:0] : trial[FADE_W-1:0];
        sh_d  = {sh_q[DutyBits-2:0], qbit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    den_q   <= den_d;
    scale_q <= scale_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire

// File: rtl/led_fade_blink_sequencer_core.sv
// LED fade/blink sequencer: each transfer on the input channel (time tick, start blink or
// fade out) yields exactly one transfer on the output channel with the PWM duty, the lit
// flag and a one-step tone pulse. Items are handled one at a time. A step that needs no
// ramp value goes from the execute state straight to the output state; a tick inside a fade
// waits in between for the ramp unit: one multiply step and then one quotient bit per
// cycle of a shared restoring divider. The input is taken again once the result has
// moved into the output register, so while the output is stalled at most one further item
// is taken in. Configuration writes are taken on any cycle and must only be issued while
// the block is idle.
`default_nettype none

module led_fade_blink_sequencer_core #(
  parameter int unsigned DutyBits = lfbs_pkg::DUTY_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  lfbs_pkg::lfbs_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output lfbs_pkg::lfbs_out_t                 out_data_o,
  input  wire                                 cfg_we_i,
  input  wire [lfbs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [lfbs_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import lfbs_pkg::*;

  localparam int unsigned PkW = DutyBits + BRIGHT_W;

  seq_state_e state_q, state_d;
  phase_e     phase_q, phase_d;

  logic [FADE_W-1:0]   fade_q;
  logic [HOLD_W-1:0]   hold_q;
  logic [BRIGHT_W-1:0] bright_q;

  lfbs_in_t            item_q;
  logic [31:0]         pstart_q, pstart_d;
  logic [15:0]         dark_q, dark_d;
  logic [1:0]          tmode_q, tmode_d;
  logic [DutyBits-1:0] level_q, level_d;
  logic                tone_q, tone_d;

  logic                out_valid_q;
  lfbs_out_t           out_q;

  logic                in_acc;
  logic                out_load;
  logic                ramp_go;
  logic [FADE_W-1:0]   ramp_num;
  lfbs_ramp_req_t      ramp_req;
  logic                ramp_done;
  logic [DutyBits-1:0] ramp_quot;

  logic [BRIGHT_W-1:0] scale;
  logic [PkW-1:0]      pk_full;
  logic [DutyBits-1:0] peak;
  logic [31:0]         elapsed;
  logic [31:0]         fade_ext;
  logic                fade_run;
  logic [DUTY_BITS_MAX-1:0] level_wide;

  assign scale    = bright_q[BRIGHT_W-1] ? BRIGHT_FULL : bright_q;
  assign pk_full  = {scale, {DutyBits{1'b0}}} - PkW'(scale);
  assign peak     = pk_full[DutyBits+7:8];
  assign elapsed  = item_q.now_ms - pstart_q;
  assign fade_ext = 32'(fade_q);
  assign fade_run = (elapsed < fade_ext);

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q   <= FADE_RST;
      hold_q   <= HOLD_RST;
      bright_q <= BRIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FADE:   fade_q   <= cfg_wdata_i[FADE_W-1:0];
        CFG_HOLD:   hold_q   <= cfg_wdata_i[HOLD_W-1:0];
        CFG_BRIGHT: bright_q <= cfg_wdata_i[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = ramp_go ? S_RAMP : S_OUT;
      S_RAMP: begin
        if (ramp_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_OUT:  out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  // step of the blink phases
  always_comb begin
    phase_d  = phase_q;
    pstart_d = pstart_q;
    dark_d   = dark_q;
    tmode_d  = tmode_q;
    level_d  = level_q;
    tone_d   = tone_q;
    ramp_go  = 1'b0;
    ramp_num = fade_q - elapsed[FADE_W-1:0];
    if (state_q == S_EXEC) begin
      tone_d = 1'b0;
      case (op_e'(item_q.opcode))
        OP_TICK: begin
          unique case (phase_q)
            PH_START: begin
              pstart_d = item_q.now_ms;
              phase_d  = PH_UP;
              tone_d   = (tmode_q == SND_START);
            end
            PH_UP: begin
              if (fade_run) begin
                ramp_go  = 1'b1;
                ramp_num = elapsed[FADE_W-1:0];
              end else begin
                level_d  = peak;
                tone_d   = (tmode_q == SND_FULL);
                pstart_d = pstart_q + fade_ext;
                phase_d  = PH_HOLD;
              end
            end
            PH_HOLD: begin
              if (elapsed >= 32'(hold_q)) begin
                pstart_d = pstart_q + 32'(hold_q);
                phase_d  = PH_DOWN;
              end
            end
            PH_DOWN: begin
              if (fade_run) begin
                ramp_go = 1'b1;
              end else begin
                level_d  = '0;
                pstart_d = pstart_q + fade_ext;
                phase_d  = PH_DARK;
              end
            end
            PH_DARK: begin
              if (elapsed >= 32'(dark_q)) begin
                pstart_d = pstart_q + 32'(dark_q);
                phase_d  = PH_IDLE;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        OP_START: begin
          phase_d = PH_START;
          dark_d  = item_q.wait_ms;
          tmode_d = item_q.sound_mode;
          level_d = '0;
        end
        OP_FADE: begin
          // mirror the current fade-up level onto the fade-down ramp, or start it from the peak when holding
          if (phase_q == PH_UP) begin
            phase_d  = PH_DOWN;
            pstart_d = {item_q.now_ms[30:0], 1'b0} - pstart_q - fade_ext;
          end else if (phase_q == PH_HOLD) begin
            phase_d  = PH_DOWN;
            pstart_d = item_q.now_ms;
          end
          dark_d = '0;
        end
        default: ;
      endcase
    end else if (ramp_done) begin
      level_d = ramp_quot;
    end
  end

  assign ramp_req = '{start: ramp_go, num: ramp_num, den: fade_q, scale: scale};

  lfbs_ramp_unit #(
    .DutyBits(DutyBits)
  ) u_ramp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ramp_req),
    .done_o(ramp_done),
    .quot_o(ramp_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      pstart_q    <= '0;
      dark_q      <= '0;
      tmode_q     <= '0;
      level_q     <= '0;
      tone_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      pstart_q <= pstart_d;
      dark_q   <= dark_d;
      tmode_q  <= tmode_d;
      level_q  <= level_d;
      tone_q   <= tone_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign level_wide = DUTY_BITS_MAX'(level_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    if (out_load) begin
      out_q.duty       <= level_wide[7:0];
      out_q.lit        <= (phase_q != PH_IDLE);
      out_q.tone_pulse <= tone_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ramp_done_in_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_done |-> (state_q == S_RAMP))
    else $error("ramp result outside ramp wait");

  a_exec_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (state_q == S_RAMP || state_q == S_OUT))
    else $error("sequencer stuck after execute");

  a_tone_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && tone_d) |=> (phase_q == PH_UP || phase_q == PH_HOLD))
    else $error("tone pulse outside fade start or peak");

  a_ramp_only_fading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_go |-> (phase_q == PH_UP || phase_q == PH_DOWN))
    else $error("ramp started outside a fade");

endmodule

`default_nettype wire
